### src/chained_packet_deframer_core_assert.svh
// Assertion helpers used by the deframer frame controller.
`ifndef CHAINED_PACKET_DEFRAMER_CORE_ASSERT_SVH
`define CHAINED_PACKET_DEFRAMER_CORE_ASSERT_SVH

// Condition holds on every clock edge out of reset.
`define CPD_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define CPD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define CPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/cpd_pkg.sv
package cpd_pkg;

    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 24;
    localparam int TOT_W     = 32;
    localparam int HDR_BYTES = 4;
    localparam int HDR_CNT_W = $clog2(HDR_BYTES + 1);

    localparam logic [HDR_CNT_W-1:0] HDR_DONE        = HDR_CNT_W'(HDR_BYTES);
    localparam logic [LEN_W-1:0]     CHUNK_LIMIT_RST = '1;
    localparam logic [TOT_W-1:0]     TOT_MAX         = '1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_READ_FAIL = 2'd1,
        ST_TOO_LARGE = 2'd2
    } t_status;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] payload_byte;
        logic              byte_valid;
        logic              last;
        logic [BYTE_W-1:0] seq_num;
        logic [TOT_W-1:0]  packet_length;
        t_status           status;
    } t_result;

endpackage

### src/cpd_frame_ctrl.sv
`include "chained_packet_deframer_core_assert.svh"

module cpd_frame_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic [cpd_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                       i_link_error,
    input  logic [cpd_pkg::LEN_W-1:0]  i_chunk_limit,
    output cpd_pkg::t_result           o_result
);
    import cpd_pkg::*;

    logic [HDR_CNT_W-1:0] r_header_count, n_header_count;
    logic [LEN_W-1:0]     r_chunk_length, n_chunk_length;
    logic [LEN_W-1:0]     r_bytes_left,   n_bytes_left;
    logic [BYTE_W-1:0]    r_last_sequence, n_last_sequence;
    logic                 r_in_chain,     n_in_chain;
    logic [TOT_W-1:0]     r_total_count,  n_total_count;

    logic                 w_in_payload;
    logic [HDR_CNT_W-1:0] w_hdr_pos;
    logic [TOT_W-1:0]     w_total_inc;

    assign w_in_payload = (r_header_count == HDR_DONE) && (r_bytes_left != '0);
    assign w_hdr_pos    = (r_header_count >= HDR_DONE) ? '0 : r_header_count;
    assign w_total_inc  = (r_total_count == TOT_MAX) ? r_total_count
                                                      : r_total_count + 1'b1;

    always_comb begin
        n_header_count  = r_header_count;
        n_chunk_length  = r_chunk_length;
        n_bytes_left    = r_bytes_left;
        n_last_sequence = r_last_sequence;
        n_in_chain      = r_in_chain;
        n_total_count   = r_total_count;

        o_result         = '0;
        o_result.seq_num = r_last_sequence;
        o_result.status  = ST_OK;

        if (i_link_error) begin
            // drop the packet so far and expect a fresh header
            n_header_count = '0;
            n_chunk_length = '0;
            n_bytes_left   = '0;
            n_in_chain     = 1'b0;
            n_total_count  = '0;
            o_result.valid  = 1'b1;
            o_result.last   = 1'b1;
            o_result.status = ST_READ_FAIL;
        end else if (w_in_payload) begin
            n_total_count         = w_total_inc;
            n_bytes_left          = r_bytes_left - 1'b1;
            o_result.valid        = 1'b1;
            o_result.byte_valid   = 1'b1;
            o_result.payload_byte = i_data_byte;
            if (r_bytes_left == LEN_W'(1)) begin
                n_header_count = '0;
                n_chunk_length = '0;
                if (!r_in_chain) begin
                    n_in_chain             = 1'b0;
                    n_total_count          = '0;
                    o_result.last          = 1'b1;
                    o_result.packet_length = w_total_inc;
                end
            end
        end else begin
            case (w_hdr_pos)
                HDR_CNT_W'(0): begin
                    n_chunk_length = LEN_W'(i_data_byte);
                    n_header_count = HDR_CNT_W'(1);
                end
                HDR_CNT_W'(1): begin
                    n_chunk_length[15:8] = i_data_byte;
                    n_header_count       = HDR_CNT_W'(2);
                end
                HDR_CNT_W'(2): begin
                    n_chunk_length[23:16] = i_data_byte;
                    n_header_count        = HDR_CNT_W'(3);
                end
                default: begin
                    // sequence byte closes the header
                    n_last_sequence  = i_data_byte;
                    o_result.seq_num = i_data_byte;
                    n_header_count   = HDR_DONE;
                    if (!r_in_chain && (r_chunk_length > i_chunk_limit)) begin
                        n_header_count  = '0;
                        n_chunk_length  = '0;
                        n_bytes_left    = '0;
                        n_in_chain      = 1'b0;
                        n_total_count   = '0;
                        o_result.valid  = 1'b1;
                        o_result.last   = 1'b1;
                        o_result.status = ST_TOO_LARGE;
                    end else if (r_chunk_length == '0) begin
                        n_header_count         = '0;
                        n_bytes_left           = '0;
                        n_in_chain             = 1'b0;
                        n_total_count          = '0;
                        o_result.valid         = 1'b1;
                        o_result.last          = 1'b1;
                        o_result.packet_length = r_total_count;
                    end else begin
                        n_in_chain   = (r_chunk_length == i_chunk_limit);
                        n_bytes_left = r_chunk_length;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_count  <= '0;
            r_chunk_length  <= '0;
            r_bytes_left    <= '0;
            r_last_sequence <= '0;
            r_in_chain      <= 1'b0;
            r_total_count   <= '0;
        end else if (i_step) begin
            r_header_count  <= n_header_count;
            r_chunk_length  <= n_chunk_length;
            r_bytes_left    <= n_bytes_left;
            r_last_sequence <= n_last_sequence;
            r_in_chain      <= n_in_chain;
            r_total_count   <= n_total_count;
        end
    end

    `CPD_ASSERT_ALWAYS(a_hdr_count_range, i_clk, i_rst_n, r_header_count <= HDR_DONE, "header count out of range")
    `CPD_ASSERT_IMP(a_payload_has_bytes, i_clk, i_rst_n, r_header_count == HDR_DONE, r_bytes_left != '0, "payload phase with no bytes left")
    `CPD_ASSERT_IMP(a_error_is_last, i_clk, i_rst_n, o_result.valid && (o_result.status != ST_OK), o_result.last && !o_result.byte_valid, "error result must be last with no byte")
    `CPD_ASSERT_NEXT(a_link_error_restart, i_clk, i_rst_n, i_step && i_link_error, (r_header_count == '0) && (r_total_count == '0) && !r_in_chain, "link error must restart the deframer")

endmodule

### src/chained_packet_deframer_core.sv
// Chained packet deframer. Takes one received byte per input transfer and strips
// length-prefixed framing: each chunk opens with a four-byte header (24-bit chunk
// length, least significant byte first, then a sequence byte), and every payload
// byte that follows comes out as one result transfer. A chunk whose length equals
// the chunk limit register chains to the next header, and the chained chunks form
// one logical packet; its final result carries last, the latest sequence byte and
// the total payload length, saturating at 2^32-1. A zero-length chunk ends the
// packet with one result that has no byte. A first chunk longer than the limit
// yields a single "too large" result, and a link error on an accepted byte yields
// a "read failed" result; both drop the packet and return to header hunting. Other
// header bytes give no result. The block sustains one byte per clock: the decode
// for a byte is combinational logic from the state registers into the output
// register, so the result appears in the cycle after its byte is accepted, and
// input is held off only while the output register is full and not taken.
// Write the chunk limit (reset 0xFFFFFF) only while the block is idle.
module chained_packet_deframer_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,

    // byte input channel
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [cpd_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                       i_link_error,

    // result channel
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [cpd_pkg::BYTE_W-1:0] o_payload_byte,
    output logic                       o_byte_valid,
    output logic                       o_last,
    output logic [cpd_pkg::BYTE_W-1:0] o_sequence_res,
    output logic [cpd_pkg::TOT_W-1:0]  o_packet_length,
    output logic [1:0]                 o_status,

    // chunk limit write channel
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [cpd_pkg::LEN_W-1:0]  i_cfg_chunk_limit
);
    import cpd_pkg::*;

    logic [LEN_W-1:0] r_chunk_limit;
    logic             r_out_valid;
    t_result          r_out;
    t_result          w_result;
    logic             w_step;

    // The limit register always takes a write in the cycle it is offered.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_limit <= CHUNK_LIMIT_RST;
        end else if (i_cfg_valid) begin
            r_chunk_limit <= i_cfg_chunk_limit;
        end
    end

    // Accept a byte whenever the output register is empty or drains this cycle.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_step     = i_in_valid && o_in_ready;

    cpd_frame_ctrl u_frame_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_step),
        .i_data_byte   (i_data_byte),
        .i_link_error  (i_link_error),
        .i_chunk_limit (r_chunk_limit),
        .o_result      (w_result)
    );

    // Output register: load a fresh result, otherwise drop the old one once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && w_result.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload needs no reset; hold it until the next result replaces it.
    always_ff @(posedge i_clk) begin
        if (w_step && w_result.valid) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_payload_byte  = r_out.payload_byte;
    assign o_byte_valid    = r_out.byte_valid;
    assign o_last          = r_out.last;
    assign o_sequence_res  = r_out.seq_num;
    assign o_packet_length = r_out.packet_length;
    assign o_status        = r_out.status;

endmodule
